>>> src/obfs_pkg.sv
// Shared types and constants for the ordered BFS all-pairs path unit.
// No dependencies; imported by the top level.
package obfs_pkg;

    localparam int MAX_VERTICES    = 64;
    localparam int MAX_DEGREE_DEF  = 8;
    localparam int VTX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int DIST_W          = 7;
    localparam int MAT_AW          = 2 * VTX_W;

    localparam logic [DIST_W-1:0] DIST_INF  = '1;
    localparam logic [DIST_W-1:0] PRED_NONE = '1;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [DIST_W-1:0] path_len;
        logic [DIST_W-1:0] pred;
        logic              reach;
    } mat_entry_t;

    localparam int MAT_W = $bits(mat_entry_t);

    typedef struct packed {
        logic [VTX_W-1:0] distance;
        logic             distance_finite;
        logic [VTX_W-1:0] predecessor;
        logic             predecessor_valid;
        logic             in_ordered_set;
        status_t          status;
    } result_t;

endpackage

>>> src/ordered_bfs_all_pairs_paths_unit.sv
// Top level of the ordered BFS all-pairs shortest path unit.
// Depends on obfs_pkg and obfs_ram.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | opcode, vertex, other_vertex
//  out      | out_valid / out_stall| distance, distance_finite, predecessor,
//           |                      | predecessor_valid, in_ordered_set, status
//  cfg      | cfg_valid / cfg_ready| cfg_data (num_vertices)
//
// Add and query go from IDLE through S_ADD or S_QRY, which await the registered
// RAM read, to S_EMIT; clear and out-of-range requests go straight to S_EMIT.
// A run goes, per source and pass, through R_START, the R_INIT sweep over all
// vertices (pass one only), R_SEED and R_DEGI; each dequeued vertex through R_POP,
// R_W, R_WD and R_ADJ, each adjacency entry through R_ADJ and R_J, and each entry
// that is not skipped through R_UPD. After reset the result matrix is swept once;
// no transaction is taken during that pass (configuration writes still are).
// A stalled result is held in the output register; the next input is taken
// meanwhile and its result waits until the register frees.
module ordered_bfs_all_pairs_paths_unit #(
    parameter int MAX_DEGREE = obfs_pkg::MAX_DEGREE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 opcode,
    input  logic [obfs_pkg::VTX_W-1:0] vertex,
    input  logic [obfs_pkg::VTX_W-1:0] other_vertex,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [obfs_pkg::VTX_W-1:0] distance,
    output logic                       distance_finite,
    output logic [obfs_pkg::VTX_W-1:0] predecessor,
    output logic                       predecessor_valid,
    output logic                       in_ordered_set,
    output logic [1:0]                 status,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [obfs_pkg::CNT_W-1:0] cfg_data
);

    import obfs_pkg::*;

    localparam int SLOT_W    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
    localparam int ADJ_DEPTH = MAX_VERTICES * (2 ** SLOT_W);
    localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ADD, S_QRY, S_EMIT,
        R_START, R_INIT, R_SEED, R_DEGI, R_POP, R_W, R_WD, R_ADJ, R_J, R_UPD
    } state_t;

    localparam mat_entry_t MAT_INIT = '{path_len: DIST_INF, pred: PRED_NONE, reach: 1'b0};

    state_t                  state_reg;
    logic [CNT_W-1:0]        num_vertices_reg;
    logic [VTX_W-1:0]        a_reg;
    logic [VTX_W-1:0]        b_reg;
    logic                    pass2_reg;
    logic [VTX_W-1:0]        i_reg;
    logic [VTX_W-1:0]        j_reg;
    logic [VTX_W-1:0]        w_reg;
    logic [CNT_W-1:0]        head_reg;
    logic [CNT_W-1:0]        tail_reg;
    logic [DEG_W-1:0]        k_reg;
    logic [DEG_W-1:0]        deg_i_reg;
    logic [DEG_W-1:0]        deg_w_reg;
    logic [DIST_W-1:0]       dist_w_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] deg_valid_reg;
    logic                    deg_vld_q_reg;
    logic [MAT_AW-1:0]       clr_reg;
    result_t                 pend_reg;
    result_t                 out_reg;
    logic                    out_valid_reg;

    // memory ports
    logic                    adj_we;
    logic [$clog2(ADJ_DEPTH)-1:0] adj_waddr, adj_raddr;
    logic [VTX_W-1:0]        adj_wdata, adj_rdata;
    logic                    deg_we;
    logic [VTX_W-1:0]        deg_waddr, deg_raddr;
    logic [DEG_W-1:0]        deg_wdata, deg_rdata;
    logic                    mat_we;
    logic [MAT_AW-1:0]       mat_waddr, mat_raddr;
    mat_entry_t              mat_wdata, mat_rdata;
    logic                    q_we;
    logic [VTX_W-1:0]        q_waddr, q_raddr;
    logic [VTX_W-1:0]        q_wdata, q_rdata;

    logic [CNT_W-1:0]        nv;
    logic [CNT_W-1:0]        nv_last;
    logic                    in_acc;
    logic                    in_range;
    logic [DEG_W-1:0]        degq;
    logic                    precedes;
    logic [DIST_W-1:0]       cand;
    logic                    shorter;
    logic                    j_skip;
    logic                    emit_free;
    logic                    emit_now;
    mat_entry_t              upd_entry;
    result_t                 res_zero;
    result_t                 res_range;
    result_t                 qry_res;

    assign nv = (num_vertices_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : num_vertices_reg;
    assign nv_last   = nv - CNT_W'(1);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign in_range  = ({1'b0, vertex} < nv) && ({1'b0, other_vertex} < nv);
    assign cfg_ready = 1'b1;
    assign degq      = deg_vld_q_reg ? deg_rdata : '0;
    assign precedes  = (degq < deg_i_reg) || ((degq == deg_i_reg) && (j_reg < i_reg));
    assign cand      = dist_w_reg + DIST_W'(1);
    assign shorter   = cand < mat_rdata.path_len;
    assign j_skip    = ({1'b0, adj_rdata} >= nv) || visited_reg[adj_rdata];
    assign emit_free = !out_valid_reg || !out_stall;
    assign emit_now  = (state_reg == S_EMIT) && emit_free;
    assign res_zero  = '{distance: '0, distance_finite: 1'b0, predecessor: '0,
                         predecessor_valid: 1'b0, in_ordered_set: 1'b0, status: ST_OK};
    assign res_range = '{distance: '0, distance_finite: 1'b0, predecessor: '0,
                         predecessor_valid: 1'b0, in_ordered_set: 1'b0, status: ST_RANGE};

    always_comb
    begin
        upd_entry.path_len = shorter ? cand : mat_rdata.path_len;
        upd_entry.pred     = (!pass2_reg || shorter) ? DIST_W'(w_reg) : mat_rdata.pred;
        upd_entry.reach    = !pass2_reg ? 1'b1 : (shorter ? 1'b0 : mat_rdata.reach);
    end

    always_comb
    begin
        qry_res = res_zero;
        if (mat_rdata.path_len != DIST_INF)
        begin
            qry_res.distance_finite = 1'b1;
            qry_res.distance        = mat_rdata.path_len[VTX_W-1:0];
        end
        if (mat_rdata.pred != PRED_NONE)
        begin
            qry_res.predecessor_valid = 1'b1;
            qry_res.predecessor       = mat_rdata.pred[VTX_W-1:0];
        end
        qry_res.in_ordered_set = mat_rdata.reach;
    end

    // memory control
    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = {a_reg, SLOT_W'(degq)};
        adj_wdata = b_reg;
        adj_raddr = {w_reg, k_reg[SLOT_W-1:0]};
        deg_we    = 1'b0;
        deg_waddr = a_reg;
        deg_wdata = degq + DEG_W'(1);
        deg_raddr = vertex;
        mat_we    = 1'b0;
        mat_waddr = {i_reg, j_reg};
        mat_wdata = MAT_INIT;
        mat_raddr = {vertex, other_vertex};
        q_we      = 1'b0;
        q_waddr   = tail_reg[VTX_W-1:0];
        q_wdata   = j_reg;
        q_raddr   = head_reg[VTX_W-1:0];
        case (state_reg)
            S_CLR:
            begin
                mat_we    = 1'b1;
                mat_waddr = clr_reg;
            end
            S_ADD:
            begin
                adj_we = (degq < DEG_W'(MAX_DEGREE));
                deg_we = (degq < DEG_W'(MAX_DEGREE));
            end
            R_INIT:
            begin
                mat_we = 1'b1;
            end
            R_SEED:
            begin
                mat_we    = 1'b1;
                mat_waddr = {i_reg, i_reg};
                mat_wdata = '{path_len: '0, pred: DIST_W'(i_reg), reach: 1'b0};
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = i_reg;
                deg_raddr = i_reg;
            end
            R_W:
            begin
                deg_raddr = q_rdata;
                mat_raddr = {i_reg, q_rdata};
            end
            R_J:
            begin
                deg_raddr = adj_rdata;
                mat_raddr = {i_reg, adj_rdata};
            end
            R_UPD:
            begin
                if (pass2_reg || precedes)
                begin
                    mat_we    = 1'b1;
                    mat_wdata = upd_entry;
                    q_we      = (tail_reg < CNT_W'(MAX_VERTICES));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            num_vertices_reg <= CNT_W'(1);
            clr_reg          <= '0;
            visited_reg      <= '0;
            deg_valid_reg    <= '0;
            deg_vld_q_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            pass2_reg        <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            k_reg            <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_vertices_reg <= cfg_data;
            end
            deg_vld_q_reg <= deg_valid_reg[deg_raddr];
            if (emit_now)
            begin
                out_reg       <= pend_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + MAT_AW'(1);
                    if (clr_reg == MAT_AW'(MAT_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        a_reg    <= vertex;
                        b_reg    <= other_vertex;
                        case (opcode)
                            OP_ADD:
                            begin
                                if (in_range)
                                begin
                                    pend_reg  <= res_zero;
                                    state_reg <= S_ADD;
                                end
                                else
                                begin
                                    pend_reg  <= res_range;
                                    state_reg <= S_EMIT;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (in_range)
                                begin
                                    pend_reg  <= res_zero;
                                    state_reg <= S_QRY;
                                end
                                else
                                begin
                                    pend_reg  <= res_range;
                                    state_reg <= S_EMIT;
                                end
                            end
                            OP_RUN:
                            begin
                                pend_reg  <= res_zero;
                                pass2_reg <= 1'b0;
                                i_reg     <= '0;
                                state_reg <= (nv == '0) ? S_EMIT : R_START;
                            end
                            default:
                            begin
                                // clear graph: drop every degree at once
                                pend_reg      <= res_zero;
                                deg_valid_reg <= '0;
                                state_reg     <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    if (degq < DEG_W'(MAX_DEGREE))
                    begin
                        deg_valid_reg[a_reg] <= 1'b1;
                    end
                    else
                    begin
                        pend_reg.status <= ST_FULL;
                    end
                    state_reg <= S_EMIT;
                end
                S_QRY:
                begin
                    pend_reg  <= qry_res;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                R_START:
                begin
                    visited_reg <= '0;
                    j_reg       <= '0;
                    state_reg   <= pass2_reg ? R_SEED : R_INIT;
                end
                R_INIT:
                begin
                    j_reg <= j_reg + VTX_W'(1);
                    if ({1'b0, j_reg} == nv_last)
                    begin
                        state_reg <= R_SEED;
                    end
                end
                R_SEED:
                begin
                    visited_reg[i_reg] <= 1'b1;
                    head_reg           <= '0;
                    tail_reg           <= CNT_W'(1);
                    state_reg          <= R_DEGI;
                end
                R_DEGI:
                begin
                    deg_i_reg <= degq;
                    state_reg <= R_POP;
                end
                R_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        // advance to the next source, to pass two, or after pass two to the result
                        if ({1'b0, i_reg} == nv_last)
                        begin
                            i_reg <= '0;
                            if (pass2_reg)
                            begin
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                pass2_reg <= 1'b1;
                                state_reg <= R_START;
                            end
                        end
                        else
                        begin
                            i_reg     <= i_reg + VTX_W'(1);
                            state_reg <= R_START;
                        end
                    end
                    else
                    begin
                        head_reg  <= head_reg + CNT_W'(1);
                        state_reg <= R_W;
                    end
                end
                R_W:
                begin
                    w_reg     <= q_rdata;
                    state_reg <= R_WD;
                end
                R_WD:
                begin
                    deg_w_reg  <= degq;
                    dist_w_reg <= mat_rdata.path_len;
                    k_reg      <= '0;
                    state_reg  <= R_ADJ;
                end
                R_ADJ:
                begin
                    if (k_reg == deg_w_reg)
                    begin
                        state_reg <= R_POP;
                    end
                    else
                    begin
                        k_reg     <= k_reg + DEG_W'(1);
                        state_reg <= R_J;
                    end
                end
                R_J:
                begin
                    j_reg     <= adj_rdata;
                    state_reg <= j_skip ? R_ADJ : R_UPD;
                end
                R_UPD:
                begin
                    if (pass2_reg || precedes)
                    begin
                        visited_reg[j_reg] <= 1'b1;
                        if (tail_reg < CNT_W'(MAX_VERTICES))
                        begin
                            tail_reg <= tail_reg + CNT_W'(1);
                        end
                    end
                    state_reg <= R_ADJ;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign distance          = out_reg.distance;
    assign distance_finite   = out_reg.distance_finite;
    assign predecessor       = out_reg.predecessor;
    assign predecessor_valid = out_reg.predecessor_valid;
    assign in_ordered_set    = out_reg.in_ordered_set;
    assign status            = out_reg.status;

    obfs_ram #(.WIDTH(VTX_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    obfs_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    obfs_ram #(.WIDTH(MAT_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    obfs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

`ifndef SYNTHESIS
    a_clr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> in_stall)
        else $error("input taken during matrix clearing pass");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == R_POP) |-> (head_reg <= tail_reg))
        else $error("search queue head passed tail");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == R_POP) |-> (tail_reg <= nv))
        else $error("search queue holds more than the vertex count");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == R_ADJ) |-> (k_reg <= deg_w_reg))
        else $error("adjacency slot beyond degree");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("undefined status code");
`endif

endmodule

>>> src/obfs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module obfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ordered_bfs_all_pairs_paths_unit.
// Depends on obfs_pkg and the unit's RTL; holds its own path-search predictor.
module tb_top;
    import obfs_pkg::*;

    localparam int NV_MAX    = 64;
    localparam int DEG_MAX   = 8;
    localparam int INF       = 'hFFFF;
    localparam int LIMIT     = 10000000;
    localparam int HOLD_LONG = 400;

    typedef struct {
        logic [5:0] distance;
        logic       distance_finite;
        logic [5:0] predecessor;
        logic       predecessor_valid;
        logic       in_ordered_set;
        status_t    status;
    } answer_t;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_stall;
    logic [1:0] opcode = OP_ADD;
    logic [5:0] vertex = 0;
    logic [5:0] other_vertex = 0;
    logic       out_valid;
    logic       out_stall = 0;
    logic [5:0] distance;
    logic       distance_finite;
    logic [5:0] predecessor;
    logic       predecessor_valid;
    logic       in_ordered_set;
    logic [1:0] status;
    logic       cfg_valid = 0;
    logic       cfg_ready;
    logic [6:0] cfg_data = 0;

    ordered_bfs_all_pairs_paths_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .vertex(vertex), .other_vertex(other_vertex),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .distance_finite(distance_finite),
        .predecessor(predecessor), .predecessor_valid(predecessor_valid),
        .in_ordered_set(in_ordered_set), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // predictor state
    int       vcount;
    int       adj_list[NV_MAX*DEG_MAX];
    int       degree[NV_MAX];
    int       dist_mat[NV_MAX*NV_MAX];
    int       pred_mat[NV_MAX*NV_MAX];
    bit       reach_mat[NV_MAX*NV_MAX];
    bit       seen[NV_MAX];
    int       bfs_fifo[NV_MAX];

    answer_t  pending_answers[$];
    int       mismatches = 0;
    int       n_items = 0;
    int       cycles = 0;
    int       burst_left = 0;
    bit       sender_eager = 0;
    int       hold_kick = 0;
    int       hold_seen = 0;
    int       hold_left = 0;

    function automatic int active_vertices();
        return (vcount > NV_MAX) ? NV_MAX : vcount;
    endfunction

    function automatic bit ranks_lower(int j, int i);
        return degree[j] < degree[i] || (degree[j] == degree[i] && j < i);
    endfunction

    task automatic search_all_pairs();
        int nv;
        int row;
        int head;
        int tail;
        int w;
        int j;
        int cand;
        bit shorter;
        nv = active_vertices();
        for (int pass = 1; pass <= 2; pass++)
        begin
            for (int i = 0; i < nv; i++)
            begin
                row = i * NV_MAX;
                head = 0;
                tail = 0;
                for (int k = 0; k < nv; k++)
                begin
                    if (pass == 1)
                    begin
                        dist_mat[row+k] = INF;
                        pred_mat[row+k] = INF;
                        reach_mat[row+k] = 0;
                    end
                    seen[k] = 0;
                end
                dist_mat[row+i] = 0;
                pred_mat[row+i] = i;
                seen[i] = 1;
                bfs_fifo[tail++] = i;
                while (head < tail)
                begin
                    w = bfs_fifo[head++];
                    for (int k = 0; k < degree[w]; k++)
                    begin
                        j = adj_list[w*DEG_MAX+k];
                        if (j >= nv) continue;
                        if (pass == 1 && !ranks_lower(j, i)) continue;
                        if (seen[j]) continue;
                        cand = dist_mat[row+w] + 1;
                        shorter = cand < dist_mat[row+j];
                        if (pass == 2 && shorter) reach_mat[row+j] = 0;
                        if (pass == 1 || shorter) pred_mat[row+j] = w;
                        if (shorter) dist_mat[row+j] = cand;
                        seen[j] = 1;
                        if (tail < NV_MAX) bfs_fifo[tail++] = j;
                        if (pass == 1) reach_mat[row+j] = 1;
                    end
                end
            end
        end
    endtask

    task automatic predict_answer(logic [1:0] op, int a, int b, output answer_t r);
        int nv;
        int idx;
        nv = active_vertices();
        r = '{default: 0, status: ST_OK};
        case (op)
            OP_ADD:
            begin
                if (a >= nv || b >= nv)
                    r.status = ST_RANGE;
                else if (degree[a] >= DEG_MAX)
                    r.status = ST_FULL;
                else
                begin
                    adj_list[a*DEG_MAX+degree[a]] = b;
                    degree[a]++;
                end
            end
            OP_RUN: search_all_pairs();
            OP_QUERY:
            begin
                if (a >= nv || b >= nv)
                    r.status = ST_RANGE;
                else
                begin
                    idx = a * NV_MAX + b;
                    if (dist_mat[idx] != INF)
                    begin
                        r.distance_finite = 1;
                        r.distance = dist_mat[idx][5:0];
                    end
                    if (pred_mat[idx] != INF)
                    begin
                        r.predecessor_valid = 1;
                        r.predecessor = pred_mat[idx][5:0];
                    end
                    r.in_ordered_set = reach_mat[idx];
                end
            end
            default:
                foreach (degree[k]) degree[k] = 0;
        endcase
    endtask

    // one input transaction; valid stays high into the next call of a burst
    task automatic send_item(logic [1:0] op, int a, int b);
        answer_t r;
        @(negedge clk);
        in_valid = 1;
        opcode = op;
        vertex = a[5:0];
        other_vertex = b[5:0];
        do @(posedge clk); while (in_stall);
        predict_answer(op, a[5:0], b[5:0], r);
        pending_answers.push_back(r);
        n_items++;
        if (!sender_eager)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                @(negedge clk);
                in_valid = 0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vertex_count(int v);
        drain();
        @(negedge clk);
        cfg_valid = 1;
        cfg_data = v[6:0];
        do @(posedge clk); while (!cfg_ready);
        vcount = v & 'h7F;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // receiver: own stall pattern, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_LONG - 1;
            out_stall <= 1;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            case ((cycles / 97) % 4)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        answer_t e;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at cycle %0d", cycles);
            end
            else
            begin
                e = pending_answers.pop_front();
                if (distance !== e.distance || distance_finite !== e.distance_finite ||
                    predecessor !== e.predecessor ||
                    predecessor_valid !== e.predecessor_valid ||
                    in_ordered_set !== e.in_ordered_set || status !== e.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch cycle %0d: exp d=%0d f=%0d p=%0d pv=%0d r=%0d s=%0d, got d=%0d f=%0d p=%0d pv=%0d r=%0d s=%0d",
                                 cycles, e.distance, e.distance_finite, e.predecessor,
                                 e.predecessor_valid, e.in_ordered_set, e.status,
                                 distance, distance_finite, predecessor,
                                 predecessor_valid, in_ordered_set, status);
                end
            end
        end
    end

    task automatic test_zero_vertices();
        write_vertex_count(0);
        send_item(OP_ADD, 0, 0);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_RUN, 0, 0);
        send_item(OP_CLEAR, 0, 0);
    endtask

    task automatic test_small_graph();
        write_vertex_count(5);
        // fill vertex 0 past its list limit
        for (int k = 0; k < DEG_MAX + 1; k++)
            send_item(OP_ADD, 0, (k % 4) + 1);
        send_item(OP_ADD, 1, 2);
        send_item(OP_ADD, 2, 3);
        send_item(OP_ADD, 5, 0);
        send_item(OP_RUN, 0, 0);
        send_item(OP_QUERY, 0, 3);
        send_item(OP_QUERY, 1, 3);
        send_item(OP_QUERY, 4, 4);
        send_item(OP_QUERY, 0, 5);
        send_item(OP_CLEAR, 0, 0);
        // matrices survive a clear until the next run
        send_item(OP_QUERY, 1, 2);
    endtask

    task automatic test_stale_neighbor();
        write_vertex_count(6);
        send_item(OP_ADD, 0, 5);
        send_item(OP_ADD, 0, 1);
        write_vertex_count(4);
        send_item(OP_RUN, 0, 0);
        send_item(OP_QUERY, 0, 1);
    endtask

    task automatic test_saturated_count();
        write_vertex_count(127);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_ADD, 63, 0);
        send_item(OP_ADD, 0, 63);
        send_item(OP_RUN, 0, 0);
        send_item(OP_QUERY, 63, 63);
        send_item(OP_QUERY, 0, 63);
        write_vertex_count(64);
        send_item(OP_QUERY, 63, 0);
    endtask

    task automatic random_phase(int nv, int n_adds, int n_queries);
        int top;
        write_vertex_count(nv);
        top = (nv < 1) ? 0 : ((nv > NV_MAX) ? NV_MAX - 1 : nv - 1);
        if ($urandom_range(0, 3) != 0) send_item(OP_CLEAR, $urandom_range(0, 63), 0);
        for (int k = 0; k < n_adds; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                          $urandom_range(0, 63));
            else if ($urandom_range(0, 15) == 0)
                send_item(OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
            else
                send_item(OP_ADD, $urandom_range(0, top), $urandom_range(0, top));
        end
        send_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
        for (int k = 0; k < n_queries; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63));
            else
                send_item(OP_QUERY, $urandom_range(0, top), $urandom_range(0, top));
        end
    endtask

    task automatic test_random_graphs();
        // one dense run at full size; the rest small or sparse, some with oversized counts
        random_phase(64, 200, 60);
        while (n_items < 700)
        begin
            sender_eager = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: random_phase($urandom_range(0, 1), 3, 4);
                1: random_phase($urandom_range(65, 127), 6, 20);
                default: random_phase($urandom_range(2, 12), $urandom_range(4, 40),
                                      $urandom_range(8, 30));
            endcase
        end
        sender_eager = 0;
    endtask

    task automatic test_output_backpressure();
        write_vertex_count(10);
        sender_eager = 1;
        @(negedge clk);
        hold_kick = hold_kick + 1;
        for (int k = 0; k < 30; k++)
            send_item(OP_QUERY, $urandom_range(0, 9), $urandom_range(0, 9));
        sender_eager = 0;
    endtask

    initial
    begin
        vcount = 1;
        foreach (degree[k]) degree[k] = 0;
        foreach (dist_mat[k])
        begin
            dist_mat[k] = INF;
            pred_mat[k] = INF;
            reach_mat[k] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        test_zero_vertices();
        test_small_graph();
        test_stale_neighbor();
        test_saturated_count();
        test_output_backpressure();
        test_random_graphs();
        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
